// ----- rtl/core/sfr_pkg.sv -----
// Shared types and constants of the streaming find-and-replace block.
// Depends on nothing; imported by all files but sfr_if.sv and sfr_checker.sv.
package sfr_pkg;

  localparam int unsigned NEEDLE_MAX_DEF = 16;
  localparam int unsigned REPL_MAX_DEF   = 16;
  localparam int unsigned LIST_MAX       = 16;
  localparam int unsigned LIST_IDX_W     = $clog2(LIST_MAX);
  localparam int unsigned LEN_W          = 5;
  localparam int unsigned TOTAL_W        = 16;
  localparam int unsigned REG_W          = 64;
  localparam int unsigned ADDR_W         = 6;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [2:0] {
    REG_NEEDLE_LO = 3'd0,
    REG_NEEDLE_HI = 3'd1,
    REG_NEEDLE_LEN = 3'd2,
    REG_REPL_LO = 3'd3,
    REG_REPL_HI = 3'd4,
    REG_REPL_LEN = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [2*REG_W-1:0] needle;
    logic [LEN_W-1:0]   needle_len;
    logic [2*REG_W-1:0] repl;
    logic [LEN_W-1:0]   repl_len;
  } cfg_t;

  // One command: a list of bytes to send, the end mark and the match count.
  typedef struct packed {
    logic [LIST_MAX-1:0][7:0] data;
    logic [LEN_W-1:0]         count;
    logic                     last;
    logic [TOTAL_W-1:0]       total;
  } cmd_t;

endpackage

// ----- rtl/core/sfr_if.sv -----
// Valid/ready channel interfaces for the text input and the result output.
// Depends on nothing.
interface sfr_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink (input valid, input text_byte, input text_last, output ready);
endinterface

interface sfr_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_present;
  logic        out_last;
  logic [15:0] match_total;

  modport source (output valid, output out_byte, output byte_present, output out_last,
                  output match_total, input ready);
  modport sink (input valid, input out_byte, input byte_present, input out_last,
                input match_total, output ready);
endinterface

// ----- rtl/core/sfr_cfg.sv -----
// APB-style register file holding the needle and the replacement.
// Depends on sfr_pkg.
module sfr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [sfr_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [sfr_pkg::REG_W-1:0]   pwdata_i,
  output logic [sfr_pkg::REG_W-1:0]   prdata_o,
  output logic                        pready_o,
  output sfr_pkg::cfg_t               cfg_o
);
  import sfr_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx      = reg_idx_e'(paddr_i[ADDR_W-1:3]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_NEEDLE_LO:  cfg_d.needle[REG_W-1:0]       = pwdata_i;
        REG_NEEDLE_HI:  cfg_d.needle[2*REG_W-1:REG_W] = pwdata_i;
        REG_NEEDLE_LEN: cfg_d.needle_len              = pwdata_i[LEN_W-1:0];
        REG_REPL_LO:    cfg_d.repl[REG_W-1:0]         = pwdata_i;
        REG_REPL_HI:    cfg_d.repl[2*REG_W-1:REG_W]   = pwdata_i;
        REG_REPL_LEN:   cfg_d.repl_len                = pwdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NEEDLE_LO:  prdata_o = cfg_q.needle[REG_W-1:0];
      REG_NEEDLE_HI:  prdata_o = cfg_q.needle[2*REG_W-1:REG_W];
      REG_NEEDLE_LEN: prdata_o = {{(REG_W-LEN_W){1'b0}}, cfg_q.needle_len};
      REG_REPL_LO:    prdata_o = cfg_q.repl[REG_W-1:0];
      REG_REPL_HI:    prdata_o = cfg_q.repl[2*REG_W-1:REG_W];
      REG_REPL_LEN:   prdata_o = {{(REG_W-LEN_W){1'b0}}, cfg_q.repl_len};
      default:        prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{needle: '0, needle_len: LEN_W'(1), repl: '0, repl_len: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/sfr_front.sv -----
// Front end: accepts text bytes, keeps the match window, compares it with the needle
// and queues back-end commands for words with bytes or end mark. Depends on sfr_pkg.
module sfr_front #(
  parameter int unsigned NEEDLE_MAX      = sfr_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned REPLACEMENT_MAX = sfr_pkg::REPL_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfr_pkg::cfg_t cfg_i,
  sfr_text_if.sink      text_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output sfr_pkg::cmd_t cmd_o
);
  import sfr_pkg::*;

  localparam int unsigned WinDepth = (NEEDLE_MAX < LIST_MAX) ? NEEDLE_MAX : LIST_MAX;
  localparam int unsigned ReplMax  = (REPLACEMENT_MAX < LIST_MAX) ? REPLACEMENT_MAX : LIST_MAX;
  localparam int unsigned FillW    = $clog2(WinDepth + 1);

  logic [WinDepth-1:0][7:0] win_q, win_d;
  logic [FillW-1:0]         fill_q, fill_d;
  logic [TOTAL_W-1:0]       total_q, total_d;

  logic [WinDepth-1:0][7:0] win_new;
  logic [FillW-1:0]         len, keep, drop, fill_new;
  logic [LEN_W-1:0]         rlen;
  logic                     full, hit, accept;

  assign text_i.ready = !queue_full_i;
  assign accept       = text_i.valid && !queue_full_i;

  // Effective lengths after clamping to the supported range.
  always_comb begin
    if (cfg_i.needle_len == '0) begin
      len = FillW'(1);
    end else if (cfg_i.needle_len > LEN_W'(WinDepth)) begin
      len = FillW'(WinDepth);
    end else begin
      len = FillW'(cfg_i.needle_len);
    end
    if (cfg_i.repl_len > LEN_W'(ReplMax)) begin
      rlen = LEN_W'(ReplMax);
    end else begin
      rlen = cfg_i.repl_len;
    end
  end

  // Keep at most len-1 of the newest bytes, then append the incoming one.
  always_comb begin
    if (fill_q >= len) begin
      keep = len - FillW'(1);
      drop = fill_q - keep;
    end else begin
      keep = fill_q;
      drop = '0;
    end
    fill_new = keep + FillW'(1);
    win_new  = '0;
    for (int i = 0; i < int'(WinDepth); i++) begin
      for (int j = 0; j < int'(WinDepth); j++) begin
        if (j == i + int'(drop)) begin
          win_new[i] = win_q[j];
        end
      end
      if (i == int'(keep)) begin
        win_new[i] = text_i.text_byte;
      end
    end
    full = (fill_new == len);
    hit  = full;
    for (int i = 0; i < int'(WinDepth); i++) begin
      if (i < int'(len) && win_new[i] != cfg_i.needle[8*i +: 8]) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    total_d = total_q;
    cmd_o   = '0;
    if (hit && total_q != '1) begin
      cmd_o.total = total_q + TOTAL_W'(1);
    end else begin
      cmd_o.total = total_q;
    end
    cmd_o.last = text_i.text_last;
    if (hit) begin
      cmd_o.data  = cfg_i.repl[8*LIST_MAX-1:0];
      cmd_o.count = rlen;
    end else begin
      for (int i = 0; i < int'(WinDepth); i++) begin
        cmd_o.data[i] = win_new[i];
      end
      if (text_i.text_last) begin
        cmd_o.count = LEN_W'(fill_new);
      end else if (full) begin
        cmd_o.count = LEN_W'(1);
      end else begin
        cmd_o.count = '0;
      end
    end
    if (accept) begin
      total_d = cmd_o.total;
      if (text_i.text_last || hit) begin
        fill_d = '0;
      end else if (full) begin
        // Oldest byte leaves the window.
        for (int i = 0; i < int'(WinDepth) - 1; i++) begin
          win_d[i] = win_new[i+1];
        end
        fill_d = len - FillW'(1);
      end else begin
        win_d  = win_new;
        fill_d = fill_new;
      end
    end
  end

  assign push_o = accept && (cmd_o.count != '0 || cmd_o.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ----- rtl/core/sfr_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on sfr_pkg.
module sfr_queue #(
  parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          head_valid_o,
  output sfr_pkg::cmd_t head_o,
  input  logic          pop_i
);
  import sfr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t [DEPTH-1:0] mem_q;
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/core/sfr_back.sv -----
// Back end: walks the head command's byte list into the output register,
// one result word per cycle while not stalled. Depends on sfr_pkg.
module sfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  sfr_pkg::cmd_t head_i,
  output logic          pop_o,
  sfr_result_if.source  result_o
);
  import sfr_pkg::*;

  logic [LIST_IDX_W-1:0] idx_q, idx_d;
  logic                  valid_q, valid_d;
  logic [7:0]            byte_q;
  logic                  present_q, last_q;
  logic [TOTAL_W-1:0]    total_q;
  logic                  load, final_byte;

  assign load       = head_valid_i && (!valid_q || result_o.ready);
  assign final_byte = (head_i.count == '0) ||
                      ({1'b0, idx_q} + LEN_W'(1) == head_i.count);
  assign pop_o      = load && final_byte;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (result_o.ready) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      idx_d   = final_byte ? '0 : idx_q + LIST_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      present_q <= (head_i.count != '0);
      byte_q    <= (head_i.count != '0) ? head_i.data[idx_q] : 8'd0;
      last_q    <= head_i.last && final_byte;
      total_q   <= head_i.total;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.out_byte     = byte_q;
  assign result_o.byte_present = present_q;
  assign result_o.out_last     = last_q;
  assign result_o.match_total  = total_q;

endmodule

// ----- rtl/core/substring_find_replace_stream_top.sv -----
// Streaming find-and-replace-all over a text byte stream.
// Text words enter on text_i (text_byte, text_last) and result words leave on
// result_o (out_byte, byte_present, out_last, match_total); both are
// valid/ready channels. The needle, the replacement and their lengths are
// written over the APB-style port, 64-bit registers at byte address 8*i, by the
// user only while the block is idle; the block itself does not enforce this.
// The front end accepts one text word per cycle while the queue is not full, compares
// the window of the newest bytes with the needle and hands at most one command to a
// two-entry queue. The back end sends one result word per cycle while the receiver
// takes them, so a word's first result is offered once it has passed through the queue
// and into the output register. Sustained rate is one text word per cycle while each
// word yields at most one result and results are taken; a match or the end of text yields
// up to sixteen result words, sent one per cycle, and input stalls once the queue is full.
// A final word with nothing left to send yields one end-only word with
// byte_present low. When the receiver stalls, the output word holds, then the
// queue fills and text_i.ready drops.
// Reset clears the window fill, the match count, the queue and the output
// valid, and loads the register reset values; no clearing pass is needed.
module substring_find_replace_stream_top #(
  parameter int unsigned NEEDLE_MAX      = sfr_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned REPLACEMENT_MAX = sfr_pkg::REPL_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sfr_text_if.sink                   text_i,
  sfr_result_if.source               result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::REG_W-1:0]  pwdata,
  output logic [sfr_pkg::REG_W-1:0]  prdata,
  output logic                       pready
);
  import sfr_pkg::*;

  cfg_t cfg;
  cmd_t cmd, head;
  logic push, full, head_valid, pop;

  // Register file.
  sfr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Window, compare and command build.
  sfr_front #(
    .NEEDLE_MAX      (NEEDLE_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .text_i       (text_i),
    .queue_full_i (full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  // The queue decouples the two halves so that each may stall on its own.
  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Result emission.
  sfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .result_o     (result_o)
  );

endmodule

// ----- rtl/core/sfr_checker.sv -----
// Port-level checks on the result channel and the register port, bound to
// the top level. Depends on nothing beyond the top level's ports.
module sfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        byte_present_i,
  input logic        out_last_i,
  input logic [15:0] match_total_i,
  input logic        pready_i
);

  // A stalled result word stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // The match count never goes down between consecutive offered words.
  a_total_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i ##1 out_valid_i |->
      match_total_i >= $past(match_total_i))
    else $error("match total decreased");

  // An end-only word carries a zero byte and the end mark.
  a_end_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_present_i |-> out_last_i && out_byte_i == 8'd0)
    else $error("malformed end-only word");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

endmodule

bind substring_find_replace_stream_top sfr_checker u_sfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_byte_i     (result_o.out_byte),
  .byte_present_i (result_o.byte_present),
  .out_last_i     (result_o.out_last),
  .match_total_i  (result_o.match_total),
  .pready_i       (pready)
);

// ----- dv/substring_find_replace_stream_top_tb.sv -----
// Self-checking bench for the streaming find-and-replace block.
// Depends on sfr_pkg, the channel interfaces in sfr_if.sv and the block's top level;
// it programs the registers over APB and checks every result word against a predictor.
module substring_find_replace_stream_top_tb;
  import sfr_pkg::*;

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES  = 5;
  // Cycles allowed after the last expected word before the registers are touched, so
  // that a text word which produced nothing has surely left the front end.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_WORDS   = 48;
  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [2:0]  REG_SPARE_6   = 3'd6;
  localparam logic [2:0]  REG_SPARE_7   = 3'd7;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // One result word as the predictor expects it.
  typedef struct packed {
    logic [7:0]         data;
    logic               present;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } text_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  sfr_text_if   text_if ();
  sfr_result_if result_if ();

  substring_find_replace_stream_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // The predictor's copy of the registers, starting from their reset values.
  logic [2*REG_W-1:0] needle_bits    = '0;
  logic [LEN_W-1:0]   needle_len_reg = 5'd1;
  logic [2*REG_W-1:0] repl_bits      = '0;
  logic [LEN_W-1:0]   repl_len_reg   = '0;

  // The predictor's copy of the block state: the window of newest text bytes (oldest
  // at entry 0), how many of its entries are valid, and the saturating match count.
  logic [7:0]         window_q [NEEDLE_MAX_DEF];
  int unsigned        window_fill = 0;
  logic [TOTAL_W-1:0] match_count = '0;

  text_word_t  out_words_due[$];
  int unsigned mismatches  = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;

  // Sender pacing: bursts of random length separated by random gaps.
  bit          tx_pacing  = 1'b0;
  int unsigned burst_left = 0;

  // Receiver stalls: an eight-bit mask is walked one bit per cycle and refilled at
  // random once it has been used up, so stall runs of varied length hit every phase.
  bit         rx_stalls   = 1'b0;
  logic [2:0] stall_phase = '0;
  logic [7:0] stall_mask  = '1;

  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 3'd1;
    if (stall_phase == 3'd7) begin
      stall_mask <= 8'($urandom) | 8'($urandom);
    end
    result_if.ready <= !rx_stalls || stall_mask[stall_phase];
  end

  // Effective needle length: zero counts as one and anything past the window size
  // saturates at it.
  function automatic int unsigned needle_span();
    if (needle_len_reg == '0) return 1;
    if (needle_len_reg > NEEDLE_MAX_DEF) return NEEDLE_MAX_DEF;
    return needle_len_reg;
  endfunction

  // Effective replacement length; zero is legal and deletes each match.
  function automatic int unsigned repl_span();
    if (repl_len_reg > REPL_MAX_DEF) return REPL_MAX_DEF;
    return repl_len_reg;
  endfunction

  function automatic void emit_word(input logic [7:0] data, input logic present);
    out_words_due.push_back('{data: data, present: present, last: 1'b0, total: match_count});
  endfunction

  // Works out the result words caused by one accepted text word and queues them.
  function automatic void find_replace_step(input logic [7:0] text_byte, input logic last);
    int unsigned span;
    int unsigned drop;
    int unsigned queued_before;
    bit          hit;
    text_word_t  tail;
    span          = needle_span();
    queued_before = out_words_due.size();
    // If the needle was shortened since the window filled, the oldest bytes are
    // dropped without being sent, leaving the newest span-1 in place.
    if (window_fill >= span) begin
      drop = window_fill - (span - 1);
      for (int i = 0; i + 1 < span; i++) window_q[i] = window_q[i + drop];
      window_fill = span - 1;
    end
    window_q[window_fill] = text_byte;
    window_fill++;
    if (window_fill == span) begin
      hit = 1'b1;
      for (int i = 0; i < span; i++) begin
        if (window_q[i] != needle_bits[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        if (match_count != TOTAL_MAX) match_count++;
        for (int i = 0; i < repl_span(); i++) emit_word(repl_bits[8*i +: 8], 1'b1);
        window_fill = 0;
      end else begin
        emit_word(window_q[0], 1'b1);
        for (int i = 0; i + 1 < span; i++) window_q[i] = window_q[i + 1];
        window_fill = span - 1;
      end
    end
    if (last) begin
      for (int i = 0; i < window_fill; i++) emit_word(window_q[i], 1'b1);
      window_fill = 0;
      // With nothing at all to send, the end of text still gets a word of its own.
      if (out_words_due.size() == queued_before) emit_word(8'h00, 1'b0);
      tail      = out_words_due.pop_back();
      tail.last = 1'b1;
      out_words_due.push_back(tail);
    end
  endfunction

  // Every accepted result word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    text_word_t seen;
    text_word_t due;
    if (rst_ni && result_if.valid && result_if.ready) begin
      seen = '{data: result_if.out_byte, present: result_if.byte_present,
               last: result_if.out_last, total: result_if.match_total};
      if (out_words_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word: expected none, got byte %02h present %0b",
                 $time, seen.data, seen.present);
        $display("  last %0b total %0d", seen.last, seen.total);
      end else begin
        due = out_words_due.pop_front();
        if (seen !== due) begin
          mismatches++;
          $display("%0t: result word mismatch: expected byte %02h present %0b last %0b total %0d",
                   $time, due.data, due.present, due.last, due.total);
          $display("  got byte %02h present %0b last %0b total %0d",
                   seen.data, seen.present, seen.last, seen.total);
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d words outstanding",
               $time, out_words_due.size());
      $display("substring_find_replace_stream_top regression: fail");
      $finish;
    end
  end

  // APB write: a setup phase, then an access phase in which the register is written,
  // then an idle phase so that back-to-back writes never toggle psel in one step.
  task automatic write_reg(input logic [2:0] idx, input logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NEEDLE_LO:  needle_bits[REG_W-1:0]       = value;
      REG_NEEDLE_HI:  needle_bits[2*REG_W-1:REG_W] = value;
      REG_NEEDLE_LEN: needle_len_reg               = value[LEN_W-1:0];
      REG_REPL_LO:    repl_bits[REG_W-1:0]         = value;
      REG_REPL_HI:    repl_bits[2*REG_W-1:REG_W]   = value;
      REG_REPL_LEN:   repl_len_reg                 = value[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offers one text word and returns once it is taken and any drawn gap is over. The valid
  // stays high for a following word unless the burst has run out and a gap is drawn.
  task automatic send_word(input logic [7:0] text_byte, input logic last);
    int unsigned gap;
    text_if.valid     <= 1'b1;
    text_if.text_byte <= text_byte;
    text_if.text_last <= last;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    find_replace_step(text_byte, last);
    words_sent++;
    if (tx_pacing) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap        = $urandom_range(0, 4);
        burst_left = $urandom_range(1, 12);
        if (gap != 0) begin
          text_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Lets the block drain fully before the registers are changed.
  task automatic wait_idle();
    text_if.valid <= 1'b0;
    while (out_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Straight after reset: a one-byte needle of zero with an empty replacement, so
  // zeros vanish from the text. The final word matches, leaving an end-only word.
  task automatic test_reset_state();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    wait_idle();
  endtask

  // Needle "abc", replacement "XY": a near miss, a match, a match on the final word,
  // then deletion with a match on the final word, and a short text flushed at the end.
  task automatic test_basic_replace();
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    write_reg(REG_NEEDLE_LO, 64'h0000_0000_0063_6261);
    write_reg(REG_NEEDLE_HI, {$urandom, $urandom});
    write_reg(REG_NEEDLE_LEN, 64'd3);
    write_reg(REG_REPL_LO, 64'h0000_0000_0000_5958);
    write_reg(REG_REPL_LEN, 64'd2);
    tx_pacing = 1'b1;
    rx_stalls = 1'b1;
    send_word(8'h61, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b1);
    wait_idle();
    write_reg(REG_REPL_LEN, 64'd0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b1);
    send_word(8'h71, 1'b1);
    wait_idle();
  endtask

  // Length registers beyond the window size saturate at sixteen, so a full-width
  // needle yields a full-width replacement; a needle length of zero acts as one.
  task automatic test_length_limits();
    logic [REG_W-1:0] low_half;
    low_half = {$urandom, $urandom};
    write_reg(REG_NEEDLE_LO, low_half);
    write_reg(REG_NEEDLE_HI, '1);
    write_reg(REG_NEEDLE_LEN, 64'd31);
    write_reg(REG_REPL_LO, '0);
    write_reg(REG_REPL_HI, '1);
    write_reg(REG_REPL_LEN, 64'd31);
    for (int i = 0; i < NEEDLE_MAX_DEF; i++) begin
      send_word(needle_bits[8*i +: 8], i == NEEDLE_MAX_DEF - 1);
    end
    wait_idle();
    write_reg(REG_NEEDLE_LEN, 64'd0);
    send_word(low_half[7:0], 1'b0);
    send_word(~low_half[7:0], 1'b1);
    wait_idle();
  endtask

  // The needle shrinks while the window still holds part of a text: the surplus
  // oldest bytes are dropped, and the kept ones complete a match with the next word.
  task automatic test_needle_shrink();
    write_reg(REG_NEEDLE_LO, 64'h4847_4645_4443_4241);
    write_reg(REG_NEEDLE_LEN, 64'd8);
    write_reg(REG_REPL_LO, 64'h23);
    write_reg(REG_REPL_LEN, 64'd1);
    send_word(8'h78, 1'b0);
    send_word(8'h79, 1'b0);
    send_word(8'h7A, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'h42, 1'b0);
    wait_idle();
    write_reg(REG_NEEDLE_LEN, 64'd3);
    send_word(8'h43, 1'b0);
    send_word(8'h44, 1'b1);
    wait_idle();
  endtask

  // Random phases, each with fresh registers and its own pacing. Texts are mostly
  // built from whole needles, needle prefixes and the bytes a to c, which form the
  // needle in most phases, so matches and near misses are common; the rest are random bytes.
  task automatic test_random_text();
    logic [7:0]         text_q[$];
    logic [2*REG_W-1:0] pattern;
    logic [LEN_W-1:0]   nlen;
    logic [LEN_W-1:0]   rlen;
    int unsigned        phase_end;
    int unsigned        text_len;
    int unsigned        pick;
    int unsigned        cut;
    int unsigned        span;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       nlen = 5'd0;
        1:       nlen = 5'd31;
        2:       nlen = 5'($urandom_range(5, 16));
        default: nlen = 5'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       rlen = 5'd0;
        1:       rlen = 5'd31;
        2:       rlen = 5'd16;
        default: rlen = 5'($urandom_range(1, 6));
      endcase
      // The first two phases pin the length extremes.
      if (p == 0) begin
        nlen = 5'd1;
        rlen = 5'd16;
      end else if (p == 1) begin
        nlen = 5'd16;
        rlen = 5'd0;
      end
      if (p % 4 == 3) begin
        pattern = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        for (int i = 0; i < 16; i++) pattern[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
      end
      write_reg(REG_NEEDLE_LO, pattern[REG_W-1:0]);
      write_reg(REG_NEEDLE_HI, pattern[2*REG_W-1:REG_W]);
      write_reg(REG_NEEDLE_LEN, 64'(nlen));
      write_reg(REG_REPL_LO, {$urandom, $urandom});
      write_reg(REG_REPL_HI, {$urandom, $urandom});
      write_reg(REG_REPL_LEN, 64'(rlen));
      tx_pacing = (p % 3) != 0;
      rx_stalls = (p % 4) != 1;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        text_len = $urandom_range(1, 24);
        span     = needle_span();
        text_q.delete();
        while (text_q.size() < text_len) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            for (int i = 0; i < span; i++) text_q.push_back(needle_bits[8*i +: 8]);
          end else if (pick == 4) begin
            cut = $urandom_range(0, span - 1);
            for (int i = 0; i < cut; i++) text_q.push_back(needle_bits[8*i +: 8]);
          end else if (pick < 8) begin
            text_q.push_back(8'h61 + 8'($urandom_range(0, 2)));
          end else begin
            text_q.push_back(8'($urandom));
          end
        end
        foreach (text_q[k]) send_word(text_q[k], k == text_q.size() - 1);
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    text_if.valid     <= 1'b0;
    text_if.text_byte <= '0;
    text_if.text_last <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_basic_replace();
    test_length_limits();
    test_needle_shrink();
    test_random_text();

    // Everything has been accepted; let the last words out, then give the block a
    // little longer in case it sends anything it should not.
    while (out_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && out_words_due.size() == 0) begin
      $display("substring_find_replace_stream_top regression: pass");
    end else begin
      $display("substring_find_replace_stream_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- substring_find_replace_stream_top.f -----
rtl/core/sfr_pkg.sv
rtl/core/sfr_if.sv
rtl/core/sfr_cfg.sv
rtl/core/sfr_front.sv
rtl/core/sfr_queue.sv
rtl/core/sfr_back.sv
rtl/core/substring_find_replace_stream_top.sv
rtl/core/sfr_checker.sv
dv/substring_find_replace_stream_top_tb.sv
